// ===== rtl/fkls_pkg.sv =====
package fkls_pkg;

   // Mixer multipliers, both taken modulo 2^32.
   localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;

   // Feature and sigmoid constants.
   localparam logic [15:0]        LENGTH_CAP    = 16'd255;
   localparam logic signed [15:0] LENGTH_OFFSET = 16'sd32;
   localparam logic signed [15:0] HASH_CENTER   = 16'sd512;
   localparam logic signed [15:0] SAT_LIMIT     = 16'sd4096;
   localparam logic [12:0]        KNEE          = 13'd1024;
   localparam logic [20:0]        HALF_SCALE_W  = 21'd500;
   localparam logic [9:0]         HALF_SCALE    = 10'd500;
   localparam logic [9:0]         FULL_SCALE    = 10'd1000;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_BIAS_TERM       = 2'd0;
   localparam logic [1:0] CSR_LENGTH_WEIGHT   = 2'd1;
   localparam logic [1:0] CSR_UPPER_WEIGHT    = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD       = 2'd3;

   // Register values after reset.
   localparam logic signed [12:0] BIAS_RESET      = -13'sd192;
   localparam logic [5:0]         LENGTH_W_RESET  = 6'd6;
   localparam logic [5:0]         UPPER_W_RESET   = 6'd4;
   localparam logic [9:0]         THRESHOLD_RESET = 10'd500;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Quotient bits of 500*m/(m+1024); the quotient is always below 500.
   localparam int QUOT_BITS = 9;

   // Linear sum; it spans about -6700 to 22700.
   typedef logic signed [15:0] sum_type;

   // Queue status seen by both of its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // One item in flight through the divider stages.
   typedef struct packed {
      logic [20:0]          rem;
      logic [12:0]          den;
      logic [QUOT_BITS-1:0] quo;
      logic                 neg;
      logic                 sat_hi;
      logic                 sat_lo;
   } div_type;

endpackage

// ===== rtl/fkls_front.sv =====
module fkls_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [47:0]             req_tdata,
   input  logic signed [12:0]      bias_term,
   input  logic [5:0]              length_weight,
   input  logic [5:0]              upper_bits_weight,
   input  fkls_pkg::q_stat_type    q_stat,
   output logic                    push,
   output fkls_pkg::sum_type       sum
);

   logic [4:0]         vld_ff, vld_in;
   logic [31:0]        hash_ff;
   logic [7:0]         len0_ff, len1_ff, len2_ff;
   logic [31:0]        mul_a_ff, mul_b_ff;
   logic [9:0]         low_ff;
   logic signed [15:0] lterm_ff;
   logic [11:0]        uterm_ff;
   fkls_pkg::sum_type  sum_ff, sum_in;

   logic               adv;
   logic [15:0]        key_length;
   logic [7:0]         len_cap;
   logic [31:0]        mix0, mix1, mixed;
   logic [31:0]        prod_a, prod_b;
   logic signed [15:0] len_off;
   logic signed [31:0] lprod;
   logic [11:0]        uprod;

   // The whole front moves together unless its last word cannot enter the queue.
   assign adv        = !vld_ff[4] || !q_stat.full;
   assign req_tready = adv;
   assign push       = adv && vld_ff[4];
   assign sum        = sum_ff;

   assign key_length = req_tdata[47:32];
   assign len_cap    = (key_length > fkls_pkg::LENGTH_CAP) ? fkls_pkg::LENGTH_CAP[7:0]
                                                           : key_length[7:0];

   assign mix0   = hash_ff ^ (hash_ff >> 16);
   assign prod_a = mix0 * fkls_pkg::MIX_MUL_A;
   assign mix1   = mul_a_ff ^ (mul_a_ff >> 15);
   assign prod_b = mix1 * fkls_pkg::MIX_MUL_B;
   assign mixed  = mul_b_ff ^ (mul_b_ff >> 16);

   assign len_off = $signed({8'b0, len2_ff}) - fkls_pkg::LENGTH_OFFSET;
   assign lprod   = 32'(len_off) * $signed({26'b0, length_weight});
   assign uprod   = {6'b0, mixed[25:20]} * {6'b0, upper_bits_weight};

   assign sum_in = $signed({{3{bias_term[12]}}, bias_term})
                 + ($signed({6'b0, low_ff}) - fkls_pkg::HASH_CENTER)
                 + lterm_ff
                 + $signed({4'b0, uterm_ff});

   assign vld_in = {vld_ff[3:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hash_ff  <= req_tdata[31:0];
         len0_ff  <= len_cap;
         mul_a_ff <= prod_a;
         len1_ff  <= len0_ff;
         mul_b_ff <= prod_b;
         len2_ff  <= len1_ff;
         low_ff   <= mixed[9:0];
         lterm_ff <= $signed(lprod[15:0]);
         uterm_ff <= uprod;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== rtl/fkls_queue.sv =====
module fkls_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  fkls_pkg::sum_type     push_data,
   input  logic                  pop,
   output fkls_pkg::sum_type     pop_data,
   output fkls_pkg::q_stat_type  q_stat
);

   fkls_pkg::sum_type                entry_ff [fkls_pkg::QUEUE_DEPTH];
   logic [fkls_pkg::QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fkls_pkg::QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fkls_pkg::QCNT_BITS-1:0]   count_ff, count_in;

   assign q_stat.full  = (count_ff == fkls_pkg::QCNT_BITS'(fkls_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/fkls_back.sv =====
module fkls_back (
   input  logic                  clock,
   input  logic                  reset,
   input  fkls_pkg::q_stat_type  q_stat,
   input  fkls_pkg::sum_type     q_data,
   output logic                  pop,
   input  logic [9:0]            candidate_threshold,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata
);

   localparam int NST = fkls_pkg::QUOT_BITS + 1;

   fkls_pkg::div_type  st_ff [NST];
   fkls_pkg::div_type  st_in [NST];
   logic [NST-1:0]     vld_ff, vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [10:0]        rsp_data_ff, rsp_data_in;

   logic               adv;
   logic [15:0]        mag;
   logic [11:0]        m;
   fkls_pkg::div_type  last;
   logic [9:0]         prob;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && !q_stat.empty;

   // Sign, saturation and the operands of 500*m/(m+1024).
   assign mag = q_data[15] ? 16'(-q_data) : q_data;
   assign m   = mag[11:0];

   always_comb begin
      logic [21:0] trial;
      st_in[0].neg    = q_data[15];
      st_in[0].sat_hi = (q_data >= fkls_pkg::SAT_LIMIT);
      st_in[0].sat_lo = (q_data <= -fkls_pkg::SAT_LIMIT);
      st_in[0].rem    = {9'b0, m} * fkls_pkg::HALF_SCALE_W;
      st_in[0].den    = {1'b0, m} + fkls_pkg::KNEE;
      st_in[0].quo    = '0;
      // One restoring step per stage, most significant quotient bit first.
      for (int k = 0; k < fkls_pkg::QUOT_BITS; k++) begin
         st_in[k+1] = st_ff[k];
         trial      = {9'b0, st_ff[k].den} << (fkls_pkg::QUOT_BITS - 1 - k);
         if ({1'b0, st_ff[k].rem} >= trial) begin
            st_in[k+1].rem = st_ff[k].rem - trial[20:0];
            st_in[k+1].quo[fkls_pkg::QUOT_BITS-1-k] = 1'b1;
         end
      end
   end

   assign vld_in = {vld_ff[NST-2:0], pop};

   assign last = st_ff[NST-1];

   always_comb begin
      if (last.sat_hi) begin
         prob = fkls_pkg::FULL_SCALE;
      end else if (last.sat_lo) begin
         prob = '0;
      end else if (last.neg) begin
         prob = fkls_pkg::HALF_SCALE - {1'b0, last.quo};
      end else begin
         prob = fkls_pkg::HALF_SCALE + {1'b0, last.quo};
      end
      rsp_data_in  = {(prob >= candidate_threshold), prob};
      rsp_valid_in = vld_ff[NST-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff       <= st_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

// ===== rtl/flow_key_logistic_score.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tdata: flow_hash[31:0], key_length[47:32]
// rsp_      out        rsp_tvalid/rsp_tready   tdata: probability[9:0], candidate[10]
// csr_      in         csr_we                  csr_addr selects, csr_wdata[12:0]
//
// One word is accepted every cycle while the result side keeps up. A word passes through 17
// registers, the first loaded by the accepting edge, before rsp_tvalid rises: five front stages
// (input, two hash multipliers, feature products, linear sum), one queue entry, one
// classification stage, nine restoring divide stages and the output register.
// Synchronous active-high reset clears all valid bits and the queue and loads the defaults.
// The front holds only on a full four-entry queue, the back only on an untaken output word.
module flow_key_logistic_score (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // flow_hash [31:0], key_length [47:32]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // probability [9:0], candidate [10], zero above
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [12:0]  csr_wdata
);

   // Configuration registers. Writes must happen only while the block is idle, which the
   // block itself does not enforce; the pipelines read them directly.
   logic signed [12:0] bias_ff, bias_in;
   logic [5:0]         len_w_ff, len_w_in;
   logic [5:0]         up_w_ff, up_w_in;
   logic [9:0]         thr_ff, thr_in;

   always_comb begin
      bias_in  = bias_ff;
      len_w_in = len_w_ff;
      up_w_in  = up_w_ff;
      thr_in   = thr_ff;
      if (csr_we) begin
         case (csr_addr)
            fkls_pkg::CSR_BIAS_TERM: begin
               bias_in = $signed(csr_wdata);
            end
            fkls_pkg::CSR_LENGTH_WEIGHT: begin
               len_w_in = csr_wdata[5:0];
            end
            fkls_pkg::CSR_UPPER_WEIGHT: begin
               up_w_in = csr_wdata[5:0];
            end
            fkls_pkg::CSR_THRESHOLD: begin
               thr_in = csr_wdata[9:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= fkls_pkg::BIAS_RESET;
         len_w_ff <= fkls_pkg::LENGTH_W_RESET;
         up_w_ff  <= fkls_pkg::UPPER_W_RESET;
         thr_ff   <= fkls_pkg::THRESHOLD_RESET;
      end else begin
         bias_ff  <= bias_in;
         len_w_ff <= len_w_in;
         up_w_ff  <= up_w_in;
         thr_ff   <= thr_in;
      end
   end

   fkls_pkg::q_stat_type q_stat;
   fkls_pkg::sum_type    push_sum;
   fkls_pkg::sum_type    pop_sum;
   logic                 push;
   logic                 pop;

   // Front: hash mixer and linear sum.
   fkls_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .bias_term         (bias_ff),
      .length_weight     (len_w_ff),
      .upper_bits_weight (up_w_ff),
      .q_stat            (q_stat),
      .push              (push),
      .sum               (push_sum)
   );

   // Short queue that decouples the two halves.
   fkls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .pop       (pop),
      .pop_data  (pop_sum),
      .q_stat    (q_stat)
   );

   // Back: saturation, pipelined divide for the sigmoid, threshold compare.
   fkls_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_stat              (q_stat),
      .q_data              (pop_sum),
      .pop                 (pop),
      .candidate_threshold (thr_ff),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata)
   );

   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("queue push while full");

   // The back never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue pop while empty");

   // A delivered probability is always within the scale.
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:0] <= fkls_pkg::FULL_SCALE))
      else $error("probability above full scale");

   // The input side only stalls while the queue is full.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_stat.full)
      else $error("input stalled without a full queue");

endmodule
